[rtl/lfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited face reconstruction package
// Shared widths, constants and control types of the reconstruction pipeline.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // Q16.16 value width and the widths of the exact intermediate results.
    localparam int VAL_W   = 32;
    localparam int DIFF_W  = VAL_W + 1;         // exact difference of two values
    localparam int SUM_W   = VAL_W + 2;         // sum of three values, biased
    localparam int MAG_W   = VAL_W;             // magnitude of a difference
    localparam int SQ_W    = 2 * MAG_W;         // square of a magnitude
    localparam int NUM_W   = SQ_W + MAG_W;      // a*a*b
    localparam int DEN_W   = SQ_W + 3;          // 4*b*b + a*a
    localparam int REM_W   = DEN_W + 1;         // shifted partial remainder
    localparam int QUO_W   = 32;                // quotient bits produced
    localparam int CORR_W  = VAL_W - 1;         // correction magnitude
    localparam int DIV_STEPS = QUO_W;           // one quotient bit per stage

    // Reciprocal of three, scaled by 2^32 and rounded down.
    localparam logic [VAL_W-2:0] RECIP3 = 31'h5555_5555;

    // Bias 3*2^31 + 1: makes the sum nonnegative and turns floor into round.
    localparam logic [SUM_W-1:0] FACE_BIAS = 34'h1_8000_0001;

    typedef logic signed [VAL_W-1:0] q16_t;

    // Control that enters one side pipeline together with its operands.
    typedef struct packed {
        logic valid;
        logic interior;
    } side_ctl_t;

endpackage

[rtl/lfr_side.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited face reconstruction, one side
// Pipelined van Albada limited correction of one cell value: differences,
// sign tests, squares, exact restoring division one quotient bit per stage,
// rounding and saturation. A new beat can enter in every cycle.
// ----------------------------------------------------------------------------
module lfr_side (
    input  logic              clk,
    input  logic              rst_n,
    input  lfr_pkg::side_ctl_t ctl_in,
    input  lfr_pkg::q16_t     face,
    input  lfr_pkg::q16_t     vertex,
    input  lfr_pkg::q16_t     cell_val,
    input  lfr_pkg::q16_t     neighbour,
    output logic              valid_out,
    output lfr_pkg::q16_t     state
);
    import lfr_pkg::*;

    // Sideband that travels with each beat through the arithmetic stages.
    typedef struct packed {
        logic              interior;
        logic              apply;
        logic              neg;
        logic [VAL_W-1:0]  cell_val;
        logic [CORR_W-1:0] bnd_mag;
    } sb_t;

    // Stage 1: exact differences.
    logic                     v1_reg;
    logic                     int1_reg;
    logic signed [DIFF_W-1:0] a1_reg;
    logic signed [DIFF_W-1:0] c1_reg;
    logic signed [DIFF_W-1:0] b1_reg;
    logic [VAL_W-1:0]         cell1_reg;

    // Stage 2: sign tests and magnitudes.
    logic             v2_reg;
    sb_t              sb2_reg;
    sb_t              sb2_next;
    logic [MAG_W-1:0] amag2_reg;
    logic [MAG_W-1:0] bmag2_reg;
    logic [DIFF_W-1:0] amag_full;
    logic [DIFF_W-1:0] bmag_full;
    logic [DIFF_W-1:0] bnd_sum;
    logic a_pos;
    logic a_neg;
    logic c_pos;
    logic c_neg;
    logic b_pos;
    logic b_neg;

    // Stage 3: squares.
    logic             v3_reg;
    sb_t              sb3_reg;
    logic [SQ_W-1:0]  asq3_reg;
    logic [SQ_W-1:0]  bsq3_reg;
    logic [MAG_W-1:0] bmag3_reg;

    // Stage 4: partial products of the numerator and the divisor.
    logic             v4_reg;
    sb_t              sb4_reg;
    logic [SQ_W-1:0]  phi4_reg;
    logic [SQ_W-1:0]  plo4_reg;
    logic [DEN_W-1:0] den4_reg;
    logic [NUM_W-1:0] num_next;

    // Divider stages; index 0 holds the dividend split and the divisor.
    logic             vld_reg [0:DIV_STEPS];
    sb_t              sb_reg  [0:DIV_STEPS];
    logic [DEN_W-1:0] den_reg [0:DIV_STEPS];
    logic [DEN_W-1:0] rem_reg [0:DIV_STEPS];
    logic [MAG_W-1:0] lo_reg  [0:DIV_STEPS-1];
    logic [QUO_W-1:0] quo_reg [1:DIV_STEPS];

    // Rounding and final add.
    logic              vr1_reg;
    sb_t               sbr1_reg;
    logic [CORR_W-1:0] mag_reg;
    logic              rnd_up;
    logic              vr2_reg;
    q16_t              state_reg;
    q16_t              state_next;
    logic signed [SUM_W-1:0] cell_wide;
    logic signed [SUM_W-1:0] mag_wide;
    logic signed [SUM_W-1:0] corr_sum;

    // ------------------------------------------------------------------
    // Valid bits of the fixed stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vr1_reg <= 1'b0;
            vr2_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= ctl_in.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            vr1_reg <= vld_reg[DIV_STEPS];
            vr2_reg <= vr1_reg;
        end
    end

    // Stage 1 payload: differences taken at full precision.
    always_ff @(posedge clk)
    begin
        int1_reg  <= ctl_in.interior;
        a1_reg    <= {face[VAL_W-1], face} - {vertex[VAL_W-1], vertex};
        c1_reg    <= {cell_val[VAL_W-1], cell_val} - {vertex[VAL_W-1], vertex};
        b1_reg    <= {neighbour[VAL_W-1], neighbour} - {cell_val[VAL_W-1], cell_val};
        cell1_reg <= cell_val;
    end

    // Stage 2: the limiter applies only where the slopes agree in sign.
    always_comb
    begin
        a_neg = a1_reg[DIFF_W-1];
        a_pos = !a1_reg[DIFF_W-1] && (|a1_reg);
        c_neg = c1_reg[DIFF_W-1];
        c_pos = !c1_reg[DIFF_W-1] && (|c1_reg);
        b_neg = b1_reg[DIFF_W-1];
        b_pos = !b1_reg[DIFF_W-1] && (|b1_reg);

        amag_full = a_neg ? (DIFF_W'(0) - DIFF_W'(a1_reg)) : DIFF_W'(a1_reg);
        bmag_full = b_neg ? (DIFF_W'(0) - DIFF_W'(b1_reg)) : DIFF_W'(b1_reg);
        // Boundary correction a/4, rounded with ties away from zero.
        bnd_sum   = amag_full + DIFF_W'(2);

        sb2_next.interior = int1_reg;
        sb2_next.apply    = ((a_pos && c_pos) || (a_neg && c_neg)) &&
                            (!int1_reg || (a_pos && b_pos) || (a_neg && b_neg));
        sb2_next.neg      = a_neg;
        sb2_next.cell_val = cell1_reg;
        sb2_next.bnd_mag  = bnd_sum[DIFF_W-1:2];
    end

    always_ff @(posedge clk)
    begin
        sb2_reg   <= sb2_next;
        amag2_reg <= amag_full[MAG_W-1:0];
        bmag2_reg <= bmag_full[MAG_W-1:0];
    end

    // Stage 3: squares of both magnitudes.
    always_ff @(posedge clk)
    begin
        sb3_reg   <= sb2_reg;
        asq3_reg  <= SQ_W'(amag2_reg) * SQ_W'(amag2_reg);
        bsq3_reg  <= SQ_W'(bmag2_reg) * SQ_W'(bmag2_reg);
        bmag3_reg <= bmag2_reg;
    end

    // Stage 4: a*a*b in two halves, and the divisor 4*b*b + a*a.
    always_ff @(posedge clk)
    begin
        sb4_reg  <= sb3_reg;
        phi4_reg <= SQ_W'(asq3_reg[SQ_W-1:MAG_W]) * SQ_W'(bmag3_reg);
        plo4_reg <= SQ_W'(asq3_reg[MAG_W-1:0]) * SQ_W'(bmag3_reg);
        den4_reg <= DEN_W'({bsq3_reg, 2'b00}) + DEN_W'(asq3_reg);
    end

    // Stage 5: full dividend; its upper part is already below the divisor.
    assign num_next = {phi4_reg, {MAG_W{1'b0}}} + NUM_W'(plo4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0]  <= sb4_reg;
        den_reg[0] <= den4_reg;
        rem_reg[0] <= DEN_W'(num_next[NUM_W-1:MAG_W]);
        lo_reg[0]  <= num_next[MAG_W-1:0];
    end

    // Restoring division, one quotient bit per stage, MSB first.
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             ge;
        logic [QUO_W-1:0] quo_prev;

        assign trial = {rem_reg[k-1], lo_reg[k-1][MAG_W-1]};
        assign diff  = trial - REM_W'(den_reg[k-1]);
        assign ge    = (trial >= REM_W'(den_reg[k-1]));

        if (k == 1)
        begin : g_first
            assign quo_prev = '0;
        end
        else
        begin : g_rest
            assign quo_prev = quo_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            sb_reg[k]  <= sb_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg[k] <= {quo_prev[QUO_W-2:0], ge};
        end

        if (k < DIV_STEPS)
        begin : g_lo
            always_ff @(posedge clk)
            begin
                lo_reg[k] <= {lo_reg[k-1][MAG_W-2:0], 1'b0};
            end
        end
    end

    // Round to nearest, ties up; the boundary face uses a/4 instead.
    assign rnd_up = ({rem_reg[DIV_STEPS], 1'b0} >= REM_W'(den_reg[DIV_STEPS]));

    always_ff @(posedge clk)
    begin
        sbr1_reg <= sb_reg[DIV_STEPS];
        if (sb_reg[DIV_STEPS].interior)
        begin
            mag_reg <= quo_reg[DIV_STEPS][CORR_W-1:0] + CORR_W'(rnd_up);
        end
        else
        begin
            mag_reg <= sb_reg[DIV_STEPS].bnd_mag;
        end
    end

    // Apply the correction with the sign of a, then clamp to 32 bits.
    always_comb
    begin
        cell_wide = SUM_W'(signed'(sbr1_reg.cell_val));
        mag_wide  = signed'(SUM_W'(mag_reg));
        corr_sum  = sbr1_reg.neg ? (cell_wide - mag_wide) : (cell_wide + mag_wide);
        if (!sbr1_reg.apply)
        begin
            state_next = sbr1_reg.cell_val;
        end
        else if (corr_sum[SUM_W-1:VAL_W-1] == '0 || corr_sum[SUM_W-1:VAL_W-1] == '1)
        begin
            state_next = corr_sum[VAL_W-1:0];
        end
        else if (corr_sum[SUM_W-1])
        begin
            state_next = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            state_next = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign valid_out = vr2_reg;
    assign state     = state_reg;

endmodule

[rtl/limited_face_reconstruction_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited face reconstruction
// MUSCL face reconstruction with the van Albada limiter for one Q16.16
// component of one face: face average, left state and right state.
// ----------------------------------------------------------------------------
// A beat is taken at every clock edge with start high; busy never rises, so
// one item per cycle streams through. The result appears on left_state,
// right_state and right_valid, marked by done for one cycle. It passes the
// face average (three stages) and each side's exact divider, which resolves
// one quotient bit per stage over 32 stages between five stages of setup
// and two of rounding and saturation. Results cannot be held back; the
// receiver takes every done beat. right_state reads zero on a boundary face.
module limited_face_reconstruction_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lfr_pkg::q16_t face_vertex_a,
    input  lfr_pkg::q16_t face_vertex_b,
    input  lfr_pkg::q16_t face_vertex_c,
    input  lfr_pkg::q16_t left_vertex,
    input  lfr_pkg::q16_t left_cell,
    input  lfr_pkg::q16_t right_vertex,
    input  lfr_pkg::q16_t right_cell,
    input  logic          right_present,
    output logic          done,
    output lfr_pkg::q16_t left_state,
    output lfr_pkg::q16_t right_state,
    output logic          right_valid
);
    import lfr_pkg::*;

    // Side operands carried alongside the face average.
    typedef struct packed {
        q16_t lv;
        q16_t lc;
        q16_t rv;
        q16_t rc;
        logic hr;
    } nbr_t;

    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    nbr_t             nb1_reg;
    nbr_t             nb2_reg;
    nbr_t             nb3_reg;
    logic [SUM_W-1:0] t1_reg;
    logic [SUM_W-1:0] t2_reg;
    logic [2*VAL_W-1:0] prod2_reg;
    q16_t             face3_reg;

    logic [VAL_W-1:0] q_est;
    logic [SUM_W-1:0] rem3;
    logic [VAL_W-1:0] q_face;

    side_ctl_t        lctl;
    side_ctl_t        rctl;
    logic             l_valid;
    logic             r_valid;
    q16_t             l_state;
    q16_t             r_state;

    // The pipeline accepts a beat in every cycle.
    assign busy = 1'b0;

    // Valid bits of the face average stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: biased sum of the three face vertices.
    always_ff @(posedge clk)
    begin
        t1_reg  <= {{2{face_vertex_a[VAL_W-1]}}, face_vertex_a} +
                   {{2{face_vertex_b[VAL_W-1]}}, face_vertex_b} +
                   {{2{face_vertex_c[VAL_W-1]}}, face_vertex_c} + FACE_BIAS;
        nb1_reg <= '{lv: left_vertex, lc: left_cell, rv: right_vertex,
                     rc: right_cell, hr: right_present};
    end

    // Stage 2: estimate of the sum over three by the scaled reciprocal.
    always_ff @(posedge clk)
    begin
        prod2_reg <= (2*VAL_W)'(t1_reg) * (2*VAL_W)'(RECIP3);
        t2_reg    <= t1_reg;
        nb2_reg   <= nb1_reg;
    end

    // Stage 3: the estimate is low by at most one; fix it and remove the bias.
    always_comb
    begin
        q_est  = prod2_reg[2*VAL_W-1:VAL_W];
        rem3   = t2_reg - (SUM_W'({q_est, 1'b0}) + SUM_W'(q_est));
        q_face = (rem3 >= SUM_W'(3)) ? (q_est + VAL_W'(1)) : q_est;
    end

    always_ff @(posedge clk)
    begin
        face3_reg <= {~q_face[VAL_W-1], q_face[VAL_W-2:0]};
        nb3_reg   <= nb2_reg;
    end

    // Left side: right cell is its neighbour, boundary rule without it.
    assign lctl = '{valid: v3_reg, interior: nb3_reg.hr};
    // Right side: runs only on interior faces, left cell is its neighbour.
    assign rctl = '{valid: v3_reg && nb3_reg.hr, interior: 1'b1};

    lfr_side u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (lctl),
        .face      (face3_reg),
        .vertex    (nb3_reg.lv),
        .cell_val  (nb3_reg.lc),
        .neighbour (nb3_reg.rc),
        .valid_out (l_valid),
        .state     (l_state)
    );

    lfr_side u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (rctl),
        .face      (face3_reg),
        .vertex    (nb3_reg.rv),
        .cell_val  (nb3_reg.rc),
        .neighbour (nb3_reg.lc),
        .valid_out (r_valid),
        .state     (r_state)
    );

    // Result beat; both sides run in lockstep.
    assign done        = l_valid;
    assign left_state  = l_state;
    assign right_valid = r_valid;
    assign right_state = r_valid ? r_state : '0;

endmodule

[tb/tb_limited_face_reconstruction_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limited face reconstruction testbench
// Streams face items through the block and checks every done beat against a
// predictor of the face average and the van Albada limited side states.
// Directed faces cover the flat, smooth, limited, rounding and clamping
// cases; random faces mix smooth fields, broken fields, raw words and range
// extremes under several sender pacing phases.
// ----------------------------------------------------------------------------
module tb_limited_face_reconstruction_top;

    // Q16.16 range limits and the offset that keeps the face average sum
    // positive before the divide.
    localparam longint Q_MAX    = 64'sd2147483647;
    localparam longint Q_MIN    = -64'sd2147483648;
    localparam longint Q_WRAP   = 64'sd4294967296;
    localparam lfr_pkg::q16_t Q_ONE  = 32'sh0001_0000;
    localparam lfr_pkg::q16_t Q_HALF = 32'sh0000_8000;
    localparam lfr_pkg::q16_t QV_MAX = 32'sh7FFF_FFFF;
    localparam lfr_pkg::q16_t QV_MIN = 32'sh8000_0000;

    localparam int NUM_PHASES       = 4;
    localparam int ITEMS_PER_PHASE  = 488;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES      = 60;
    localparam int REPORT_LIMIT     = 10;

    // One face component as the sender presents it. A hold entry carries no
    // face; it makes the sender wait until every due result has come back.
    typedef struct {
        lfr_pkg::q16_t fva;
        lfr_pkg::q16_t fvb;
        lfr_pkg::q16_t fvc;
        lfr_pkg::q16_t lv;
        lfr_pkg::q16_t lc;
        lfr_pkg::q16_t rv;
        lfr_pkg::q16_t rc;
        logic          right_present;
        int unsigned   idle_pct;
        bit            hold;
    } face_item_t;

    typedef struct {
        lfr_pkg::q16_t left;
        lfr_pkg::q16_t right;
        logic          rvalid;
    } face_states_t;

    logic          clk;
    logic          rst_n         = 1'b0;
    logic          start         = 1'b0;
    logic          busy;
    lfr_pkg::q16_t face_vertex_a = '0;
    lfr_pkg::q16_t face_vertex_b = '0;
    lfr_pkg::q16_t face_vertex_c = '0;
    lfr_pkg::q16_t left_vertex   = '0;
    lfr_pkg::q16_t left_cell     = '0;
    lfr_pkg::q16_t right_vertex  = '0;
    lfr_pkg::q16_t right_cell    = '0;
    logic          right_present = 1'b0;
    logic          done;
    lfr_pkg::q16_t left_state;
    lfr_pkg::q16_t right_state;
    logic          right_valid;

    face_item_t   faces_to_send[$];
    face_states_t states_due[$];
    face_item_t   face_on_bus;
    face_states_t state_want;
    int unsigned  cur_idle_pct;

    int unsigned  n_errors        = 0;
    int unsigned  n_accepted      = 0;
    int unsigned  n_results       = 0;
    int unsigned  n_interior      = 0;
    int unsigned  n_boundary      = 0;
    int unsigned  n_limited       = 0;
    int unsigned  n_slope_applied = 0;
    int unsigned  n_kept          = 0;
    int unsigned  n_clamped       = 0;
    int unsigned  quiet_cycles    = 0;

    limited_face_reconstruction_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .face_vertex_a (face_vertex_a),
        .face_vertex_b (face_vertex_b),
        .face_vertex_c (face_vertex_c),
        .left_vertex   (left_vertex),
        .left_cell     (left_cell),
        .right_vertex  (right_vertex),
        .right_cell    (right_cell),
        .right_present (right_present),
        .done          (done),
        .left_state    (left_state),
        .right_state   (right_state),
        .right_valid   (right_valid)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // State of one side: the cell value plus the limited slope when the face
    // and cell differences agree in sign (and, inside, the neighbour too).
    function automatic lfr_pkg::q16_t reconstruct_side(longint face, longint vert,
                                                       longint cell_val, longint nbr,
                                                       bit boundary);
        longint            d_face;
        longint            d_cell;
        longint            d_nbr;
        longint            total;
        longint unsigned   mag_a;
        longint unsigned   mag_b;
        longint unsigned   slope;
        bit [127:0]        sq_a;
        bit [127:0]        sq_b;
        bit [127:0]        num;
        bit [127:0]        den;
        bit [127:0]        quo;
        bit [127:0]        rem;
        d_face = face - vert;
        d_cell = cell_val - vert;
        d_nbr  = nbr - cell_val;
        if (d_face == 0 || d_cell == 0 || ((d_face > 0) != (d_cell > 0)))
        begin
            n_kept++;
            return lfr_pkg::q16_t'(cell_val);
        end
        mag_a = (d_face > 0) ? d_face : -d_face;
        if (boundary)
        begin
            slope = (mag_a + 2) >> 2;
            n_slope_applied++;
        end
        else
        begin
            if (d_nbr == 0 || ((d_nbr > 0) != (d_face > 0)))
            begin
                n_kept++;
                return lfr_pkg::q16_t'(cell_val);
            end
            mag_b = (d_nbr > 0) ? d_nbr : -d_nbr;
            sq_a = 128'(mag_a);
            sq_a = sq_a * 128'(mag_a);
            sq_b = 128'(mag_b);
            sq_b = sq_b * 128'(mag_b);
            num  = sq_a * 128'(mag_b);
            den  = (sq_b << 2) + sq_a;
            quo  = num / den;
            rem  = num % den;
            if ((rem << 1) >= den)
                quo = quo + 1;
            slope = quo[63:0];
            n_limited++;
        end
        total = (d_face > 0) ? cell_val + longint'(slope) : cell_val - longint'(slope);
        if (total > Q_MAX || total < Q_MIN)
            n_clamped++;
        if (total > Q_MAX)
            total = Q_MAX;
        else if (total < Q_MIN)
            total = Q_MIN;
        return lfr_pkg::q16_t'(total);
    endfunction

    // Face average rounded to nearest, then the left and right side states.
    function automatic face_states_t predict_face_states(face_item_t it);
        longint       sum3;
        longint       face;
        face_states_t res;
        sum3 = longint'(it.fva) + longint'(it.fvb) + longint'(it.fvc);
        face = (sum3 + 1 + 3 * Q_WRAP) / 3 - Q_WRAP;
        if (it.right_present)
        begin
            n_interior++;
            res.left   = reconstruct_side(face, it.lv, it.lc, it.rc, 1'b0);
            res.right  = reconstruct_side(face, it.rv, it.rc, it.lc, 1'b0);
            res.rvalid = 1'b1;
        end
        else
        begin
            n_boundary++;
            res.left   = reconstruct_side(face, it.lv, it.lc, 0, 1'b1);
            res.right  = '0;
            res.rvalid = 1'b0;
        end
        return res;
    endfunction

    function automatic lfr_pkg::q16_t clamp_q(longint v);
        if (v > Q_MAX)
            return QV_MAX;
        if (v < Q_MIN)
            return QV_MIN;
        return lfr_pkg::q16_t'(v);
    endfunction

    // Random offset within a quarter of the gradient either way.
    function automatic longint jitter(longint grad);
        longint span;
        span = ((grad < 0) ? -grad : grad) / 4;
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic lfr_pkg::q16_t edge_value();
        case ($urandom_range(5))
            0:       return QV_MIN;
            1:       return QV_MAX;
            2:       return QV_MIN + 1;
            3:       return QV_MAX - 1;
            4:       return '0;
            default: return lfr_pkg::q16_t'($urandom);
        endcase
    endfunction

    // A nearly linear field across left vertex, left cell, face, right cell
    // and right vertex, so both limiter tests pass; a broken field spoils
    // the ordering in one place.
    function automatic face_item_t smooth_face(bit broken);
        face_item_t  it;
        longint      base;
        longint      grad;
        int unsigned bits;
        base = longint'($signed($urandom));
        if ($urandom_range(1))
            base = base / (longint'(1) << $urandom_range(0, 16));
        bits = $urandom_range(2, 29);
        grad = longint'($urandom_range(1, 1 << bits));
        if ($urandom_range(1))
            grad = -grad;
        it.fva = clamp_q(base + 2 * grad + jitter(grad));
        it.fvb = clamp_q(base + 2 * grad + jitter(grad));
        it.fvc = clamp_q(base + 2 * grad + jitter(grad));
        it.lv  = clamp_q(base);
        it.lc  = clamp_q(base + grad + jitter(grad));
        it.rc  = clamp_q(base + 3 * grad + jitter(grad));
        it.rv  = clamp_q(base + 4 * grad);
        if (broken)
        begin
            case ($urandom_range(3))
                0:       it.lc  = clamp_q(base - grad);
                1:       it.rc  = clamp_q(base + 5 * grad);
                2:       it.fvb = clamp_q(base - 3 * grad);
                default: it.rv  = clamp_q(base + grad / 2);
            endcase
        end
        it.right_present = ($urandom_range(3) != 0);
        it.idle_pct      = cur_idle_pct;
        it.hold          = 1'b0;
        return it;
    endfunction

    task automatic queue_face(lfr_pkg::q16_t fa, lfr_pkg::q16_t fb, lfr_pkg::q16_t fc,
                              lfr_pkg::q16_t lv, lfr_pkg::q16_t lc,
                              lfr_pkg::q16_t rv, lfr_pkg::q16_t rc, logic hr);
        face_item_t it;
        it.fva = fa;
        it.fvb = fb;
        it.fvc = fc;
        it.lv  = lv;
        it.lc  = lc;
        it.rv  = rv;
        it.rc  = rc;
        it.right_present = hr;
        it.idle_pct      = cur_idle_pct;
        it.hold          = 1'b0;
        faces_to_send.push_back(it);
    endtask

    task automatic queue_hold();
        face_item_t it;
        it      = '{default: '0};
        it.hold = 1'b1;
        faces_to_send.push_back(it);
    endtask

    task automatic queue_random_face();
        face_item_t  it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            it = smooth_face(1'b0);
        else if (pick < 70)
            it = smooth_face(1'b1);
        else
        begin
            it = smooth_face(1'b0);
            if (pick < 90)
            begin
                it.fva = $urandom;  it.fvb = $urandom;  it.fvc = $urandom;
                it.lv  = $urandom;  it.lc  = $urandom;
                it.rv  = $urandom;  it.rc  = $urandom;
            end
            else
            begin
                it.fva = edge_value();  it.fvb = edge_value();  it.fvc = edge_value();
                it.lv  = edge_value();  it.lc  = edge_value();
                it.rv  = edge_value();  it.rc  = edge_value();
            end
        end
        faces_to_send.push_back(it);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (n_errors < REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        n_errors++;
    endtask

    // Stimulus: directed faces, then random faces in pacing phases, with a
    // full drain between phases.
    initial
    begin
        int unsigned phase_idle[NUM_PHASES];
        phase_idle[0] = 0;    // back to back
        phase_idle[1] = 88;   // sparse sender
        phase_idle[2] = 0;    // back to back again: done cannot be held off
        phase_idle[3] = 37;   // moderate gaps

        cur_idle_pct = 0;
        // Flat field and plain boundary.
        queue_face(0, 0, 0, 0, 0, 0, 0, 1'b1);
        queue_face(0, 0, 0, 0, 0, 0, 0, 1'b0);
        // Smooth field, limited on both sides, and as a boundary face.
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, Q_HALF, 2 * Q_ONE, 3 * Q_HALF, 1'b1);
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, Q_HALF, 2 * Q_ONE, 3 * Q_HALF, 1'b0);
        // Face and cell differences of opposite sign.
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, -Q_HALF, 2 * Q_ONE, 3 * Q_HALF, 1'b1);
        // Neighbour difference against the face difference.
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, Q_HALF, 2 * Q_ONE, 0, 1'b1);
        // Equal cells: no neighbour difference.
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, Q_HALF, 2 * Q_ONE, Q_HALF, 1'b1);
        // Cell equal to its vertex.
        queue_face(Q_ONE, Q_ONE, Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE, 1'b1);
        // Boundary slope ties, both signs.
        queue_face(2, 2, 2, 0, 1, 0, 0, 1'b0);
        queue_face(-2, -2, -2, 0, -1, 0, 0, 1'b0);
        // Limiter at its peak: neighbour difference half the face difference.
        queue_face(4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 0, Q_ONE, 5 * Q_ONE, 3 * Q_ONE, 1'b1);
        // Face average rounding by thirds.
        queue_face(1, 0, 0, 0, 0, 0, 0, 1'b1);
        queue_face(1, 1, 0, 0, 1, 0, 0, 1'b0);
        queue_face(-1, 0, 0, 0, -1, 0, 0, 1'b0);
        queue_face(-1, -1, 0, 0, -1, 0, 0, 1'b0);
        // Clamping at both ends of the range.
        queue_face(QV_MAX, QV_MAX, QV_MAX, QV_MIN, QV_MAX, QV_MIN, QV_MAX, 1'b0);
        queue_face(QV_MIN, QV_MIN, QV_MIN, QV_MAX, QV_MIN, QV_MAX, QV_MIN, 1'b0);
        // Widest differences through the limiter.
        queue_face(QV_MAX, QV_MAX, QV_MAX, QV_MIN, 32'sh7000_0000, QV_MIN, QV_MAX, 1'b1);
        queue_face(QV_MIN, QV_MIN, QV_MIN, QV_MAX, 32'sh9000_0000, QV_MAX, QV_MIN, 1'b1);
        queue_face(QV_MAX, QV_MAX, QV_MAX, QV_MAX, QV_MAX, QV_MAX, QV_MAX, 1'b1);
        queue_face(QV_MIN, QV_MIN, QV_MIN, QV_MIN, QV_MIN, QV_MIN, QV_MIN, 1'b1);
        queue_face(QV_MAX, QV_MIN, QV_MAX, QV_MIN, QV_MAX, QV_MAX, QV_MIN, 1'b1);
        queue_face(QV_MIN, QV_MAX, QV_MIN, QV_MAX, QV_MIN, QV_MIN, QV_MAX, 1'b1);
        queue_hold();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cur_idle_pct = phase_idle[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_random_face();
            queue_hold();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (faces_to_send.size() != 0 || start)
            @(posedge clk);
        while (states_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (states_due.size() != 0)
        begin
            $display("%0d results never arrived", states_due.size());
            n_errors++;
        end
        $display("Sent %0d faces (%0d interior, %0d boundary) over four pacing phases.",
                 n_accepted, n_interior, n_boundary);
        $display("Sides: %0d limited, %0d boundary slopes, %0d kept cell, %0d clamped.",
                 n_limited, n_slope_applied, n_kept, n_clamped);
        if (n_errors == 0)
            $display("tb_limited_face_reconstruction_top: clean");
        else
            $display("tb_limited_face_reconstruction_top: errors");
        $finish;
    end

    // Sender: records the prediction for every accepted beat, then presents
    // the next face or idles according to the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                states_due.push_back(predict_face_states(face_on_bus));
                n_accepted++;
            end
            if (!(start && busy))
            begin
                if (faces_to_send.size() == 0)
                    start <= 1'b0;
                else if (faces_to_send[0].hold)
                begin
                    start <= 1'b0;
                    if (states_due.size() == 0 && !done)
                        void'(faces_to_send.pop_front());
                end
                else if ($urandom_range(99) < faces_to_send[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    face_on_bus    = faces_to_send.pop_front();
                    face_vertex_a <= face_on_bus.fva;
                    face_vertex_b <= face_on_bus.fvb;
                    face_vertex_c <= face_on_bus.fvc;
                    left_vertex   <= face_on_bus.lv;
                    left_cell     <= face_on_bus.lc;
                    right_vertex  <= face_on_bus.rv;
                    right_cell    <= face_on_bus.rc;
                    right_present <= face_on_bus.right_present;
                    start         <= 1'b1;
                end
            end
        end
    end

    // Receiver: every done beat is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (states_due.size() == 0)
                report_mismatch("unrequested result, left_state", 'x, left_state);
            else
            begin
                state_want = states_due.pop_front();
                n_results++;
                if (left_state !== state_want.left)
                    report_mismatch("left_state", state_want.left, left_state);
                if (right_state !== state_want.right)
                    report_mismatch("right_state", state_want.right, right_state);
                if (right_valid !== state_want.rvalid)
                    report_mismatch("right_valid", {31'b0, state_want.rvalid},
                                    {31'b0, right_valid});
            end
        end
    end

    // Watchdog on cycles with neither an accepted face nor a result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d quiet cycles, %0d results pending",
                         quiet_cycles, states_due.size());
                $display("tb_limited_face_reconstruction_top: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[limited_face_reconstruction_top.f]
rtl/lfr_pkg.sv
rtl/lfr_side.sv
rtl/limited_face_reconstruction_top.sv
tb/tb_limited_face_reconstruction_top.sv
